>>> rtl/chcl_pkg.sv
// Shared types and constants for the convex hull chain length unit.
// No dependencies; used by chcl_ctrl, chcl_dp and the top level.
package chcl_pkg;

   localparam int COORD_W   = 24;
   localparam int LEN_W     = 34;
   localparam int HULL_W    = 9;
   localparam int STAT_W    = 2;
   localparam int SQ_W      = 50;   // radicand width: dx^2 + dz^2 < 2^50
   localparam int ROOT_W    = 25;
   localparam int SQRT_STEPS = 25;  // one root bit per cycle

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_DROPPED  = 2'd2,
      STAT_OPEN     = 2'd3
   } status_type;

   // controller -> datapath commands
   typedef struct packed {
      logic wr;         // store incoming word
      logic rd;         // read store entry into read register
      logic lm_load;    // leftmost x <= read x
      logic p_load;     // p point <= read data
      logic q_load;     // q point <= read data
      logic p_from_q;   // p point <= q point
      logic mul_turn;   // register both cross product terms
      logic mul_edge;   // register dx^2 and dz^2
      logic sq_start;   // load root unit with sum of squares
      logic sq_step;    // one root iteration
      logic acc;        // add root to length, saturating
      logic len_clr;    // clear length
      logic out_load;   // length -> result register
   } dp_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic lm_less;    // read x < leftmost x
      logic ccw;        // counterclockwise turn
   } dp_stat_type;

endpackage

>>> rtl/chcl_dp.sv
// Datapath: point store, cross product terms, bit-serial root, length sum.
// Depends on chcl_pkg; commanded by chcl_ctrl.
module chcl_dp #(
   parameter int IW = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  chcl_pkg::dp_cmd_type          cmd,
   input  logic [IW-1:0]                 wr_addr,
   input  logic [IW-1:0]                 rd_addr,
   input  logic [chcl_pkg::COORD_W-1:0]  wr_x,
   input  logic [chcl_pkg::COORD_W-1:0]  wr_z,
   output chcl_pkg::dp_stat_type         stat,
   output logic [chcl_pkg::LEN_W-1:0]    chain_length
);

   localparam int CW = chcl_pkg::COORD_W;
   localparam int SW = chcl_pkg::SQ_W;

   logic [CW-1:0] x_mem [2**IW];
   logic [CW-1:0] z_mem [2**IW];

   logic signed [CW-1:0] rd_x_ff, rd_z_ff, xl_ff;
   logic signed [CW-1:0] xp_ff, zp_ff, xq_ff, zq_ff;
   logic signed [2*CW+1:0] pa_ff, pb_ff;
   logic signed [2*CW+1:0] pa_in, pb_in, sqx_in, sqz_in;
   logic [SW-1:0] sqx_ff, sqz_ff;
   logic [SW-1:0] sv_ff, sres_ff, sbit_ff;
   logic [SW:0]   trial;
   logic [chcl_pkg::LEN_W:0] sum;
   logic [chcl_pkg::LEN_W-1:0] len_ff, out_ff;
   logic signed [CW:0] dzi, dxq, dxi, dzq, dx, dz;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         x_mem[wr_addr] <= wr_x;
         z_mem[wr_addr] <= wr_z;
      end
      if (cmd.rd) begin
         rd_x_ff <= x_mem[rd_addr];
         rd_z_ff <= z_mem[rd_addr];
      end
   end

   always_comb begin
      dzi = $signed({rd_z_ff[CW-1], rd_z_ff}) - $signed({zp_ff[CW-1], zp_ff});
      dxq = $signed({xq_ff[CW-1], xq_ff}) - $signed({rd_x_ff[CW-1], rd_x_ff});
      dxi = $signed({rd_x_ff[CW-1], rd_x_ff}) - $signed({xp_ff[CW-1], xp_ff});
      dzq = $signed({zq_ff[CW-1], zq_ff}) - $signed({rd_z_ff[CW-1], rd_z_ff});
      dx  = $signed({xp_ff[CW-1], xp_ff}) - $signed({xq_ff[CW-1], xq_ff});
      dz  = $signed({zp_ff[CW-1], zp_ff}) - $signed({zq_ff[CW-1], zq_ff});
      pa_in  = dzi * dxq;
      pb_in  = dxi * dzq;
      sqx_in = dx * dx;
      sqz_in = dz * dz;
      trial  = {1'b0, sres_ff} + {1'b0, sbit_ff};
      sum    = {1'b0, len_ff} + (chcl_pkg::LEN_W+1)'(sres_ff[chcl_pkg::ROOT_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.lm_load) xl_ff <= rd_x_ff;
      if (cmd.p_load) begin
         xp_ff <= rd_x_ff;
         zp_ff <= rd_z_ff;
      end else if (cmd.p_from_q) begin
         xp_ff <= xq_ff;
         zp_ff <= zq_ff;
      end
      if (cmd.q_load) begin
         xq_ff <= rd_x_ff;
         zq_ff <= rd_z_ff;
      end
      if (cmd.mul_turn) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (cmd.mul_edge) begin
         sqx_ff <= SW'(sqx_in);
         sqz_ff <= SW'(sqz_in);
      end
      if (cmd.sq_start) begin
         sv_ff   <= sqx_ff + sqz_ff;
         sres_ff <= '0;
         sbit_ff <= SW'(1) << (2 * (chcl_pkg::SQRT_STEPS - 1));
      end else if (cmd.sq_step) begin
         if ({1'b0, sv_ff} >= trial) begin
            sv_ff   <= sv_ff - SW'(trial);
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
      end
      if (cmd.out_load) out_ff <= len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.len_clr) begin
         len_ff <= '0;
      end else if (cmd.acc) begin
         len_ff <= (sum > {1'b0, chcl_pkg::LEN_MAX}) ? chcl_pkg::LEN_MAX
                                                     : sum[chcl_pkg::LEN_W-1:0];
      end
   end

   assign stat.lm_less = rd_x_ff < xl_ff;
   assign stat.ccw     = pa_ff < pb_ff;
   assign chain_length = out_ff;

endmodule

>>> rtl/chcl_ctrl.sv
// Controller: load sequencing, leftmost search, wrap scan, edge and result control.
// Depends on chcl_pkg; drives chcl_dp.
module chcl_ctrl #(
   parameter int MAX_POINTS = 256,
   parameter int IW = 8,
   parameter int CW = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_last_point,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [chcl_pkg::HULL_W-1:0]  rsp_hull_count,
   output logic [chcl_pkg::STAT_W-1:0]  rsp_status,
   output chcl_pkg::dp_cmd_type         cmd,
   output logic [IW-1:0]                wr_addr,
   output logic [IW-1:0]                rd_addr,
   input  chcl_pkg::dp_stat_type        stat
);

   typedef enum logic [4:0] {
      ST_LOAD, ST_START, ST_LM_RD, ST_LM_CMP, ST_P_RD, ST_P_LD, ST_Q_RD, ST_Q_LD,
      ST_SC_RD, ST_SC_MUL, ST_SC_CMP, ST_ROUND_END, ST_E_MUL, ST_E_SQ0, ST_E_SQ,
      ST_E_ACC, ST_FIN
   } state_type;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, vis_ff, vis_in;
   logic [IW-1:0] i_ff, i_in, l_ff, l_in, p_ff, p_in, q_ff, q_in;
   logic [4:0]    sq_ff, sq_in;
   logic          drop_ff, drop_in, rv_ff, rv_in;
   logic [chcl_pkg::HULL_W-1:0] hc_ff, hc_in;
   chcl_pkg::status_type st_ff, st_in, fin_ff, fin_in;
   logic          accept, i_last;
   logic [CW-1:0] p_next;

   assign accept = (state_ff == ST_LOAD) && req_valid;
   assign i_last = (CW'(i_ff) == cnt_ff - CW'(1));
   assign p_next = CW'(p_ff) + CW'(1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      vis_in   = vis_ff;
      i_in     = i_ff;
      l_in     = l_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      sq_in    = sq_ff;
      drop_in  = drop_ff;
      rv_in    = rv_ff && rsp_stall;
      hc_in    = hc_ff;
      st_in    = st_ff;
      fin_in   = fin_ff;
      cmd      = '0;
      wr_addr  = cnt_ff[IW-1:0];
      rd_addr  = i_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (cnt_ff < MAX_CNT) begin
                  cmd.wr = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_point) begin
                  cmd.len_clr = 1'b1;
                  state_in    = ST_START;
               end
            end
         end
         ST_START: begin
            vis_in = '0;
            i_in   = '0;
            l_in   = '0;
            if (cnt_ff == '0) begin
               fin_in   = chcl_pkg::STAT_EMPTY;
               state_in = ST_FIN;
            end else begin
               state_in = ST_LM_RD;
            end
         end
         ST_LM_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_LM_CMP;
         end
         ST_LM_CMP: begin
            if (i_ff == '0 || stat.lm_less) begin
               cmd.lm_load = 1'b1;
               l_in        = i_ff;
            end
            if (i_last) begin
               state_in = ST_P_RD;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_LM_RD;
            end
         end
         ST_P_RD: begin
            rd_addr  = l_ff;
            cmd.rd   = 1'b1;
            p_in     = l_ff;
            state_in = ST_P_LD;
         end
         ST_P_LD: begin
            cmd.p_load = 1'b1;
            state_in   = ST_Q_RD;
         end
         ST_Q_RD: begin
            // first candidate: next stored point, wrapping to index 0
            q_in     = (p_next == cnt_ff) ? '0 : p_next[IW-1:0];
            rd_addr  = q_in;
            cmd.rd   = 1'b1;
            vis_in   = vis_ff + CW'(1);
            state_in = ST_Q_LD;
         end
         ST_Q_LD: begin
            cmd.q_load = 1'b1;
            i_in       = '0;
            state_in   = ST_SC_RD;
         end
         ST_SC_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_SC_MUL;
         end
         ST_SC_MUL: begin
            cmd.mul_turn = 1'b1;
            state_in     = ST_SC_CMP;
         end
         ST_SC_CMP: begin
            if (stat.ccw) begin
               cmd.q_load = 1'b1;
               q_in       = i_ff;
            end
            if (i_last) begin
               state_in = ST_ROUND_END;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_SC_RD;
            end
         end
         ST_ROUND_END: begin
            if (q_ff == l_ff) begin
               fin_in   = drop_ff ? chcl_pkg::STAT_DROPPED : chcl_pkg::STAT_OK;
               state_in = ST_FIN;
            end else if (vis_ff >= cnt_ff) begin
               fin_in   = chcl_pkg::STAT_OPEN;
               state_in = ST_FIN;
            end else begin
               state_in = ST_E_MUL;
            end
         end
         ST_E_MUL: begin
            cmd.mul_edge = 1'b1;
            state_in     = ST_E_SQ0;
         end
         ST_E_SQ0: begin
            cmd.sq_start = 1'b1;
            sq_in        = '0;
            state_in     = ST_E_SQ;
         end
         ST_E_SQ: begin
            cmd.sq_step = 1'b1;
            sq_in       = sq_ff + 5'd1;
            if (sq_ff == 5'(chcl_pkg::SQRT_STEPS - 1)) state_in = ST_E_ACC;
         end
         ST_E_ACC: begin
            cmd.acc      = 1'b1;
            cmd.p_from_q = 1'b1;
            p_in         = q_ff;
            state_in     = ST_Q_RD;
         end
         ST_FIN: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rv_in        = 1'b1;
               hc_in        = chcl_pkg::HULL_W'(vis_ff);
               st_in        = fin_ff;
               cnt_in       = '0;
               drop_in      = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         rv_ff    <= rv_in;
      end
      vis_ff <= vis_in;
      i_ff   <= i_in;
      l_ff   <= l_in;
      p_ff   <= p_in;
      q_ff   <= q_in;
      sq_ff  <= sq_in;
      hc_ff  <= hc_in;
      st_ff  <= st_in;
      fin_ff <= fin_in;
   end

   assign req_stall      = (state_ff != ST_LOAD);
   assign rsp_valid      = rv_ff;
   assign rsp_hull_count = hc_ff;
   assign rsp_status     = st_ff;

endmodule

>>> rtl/convex_hull_chain_length_unit.sv
// Channel   Dir  Ports                                          Word
// req       in   req_valid/req_stall, req_x_coord, req_z_coord, req_last_point
// rsp       out  rsp_valid/rsp_stall, rsp_chain_length, rsp_hull_count, rsp_status
//
// Points load one per cycle while req_stall is low. After the last point the wrap
// scan runs until the result word is valid: each candidate needs a store read, a multiply
// and a compare; each edge then runs the bit-serial root unit. Reset is synchronous
// and clears the point count. Points are still taken while a result waits on
// rsp_stall; the next result holds until that word is taken.
// Depends on chcl_pkg, chcl_ctrl, chcl_dp.
module convex_hull_chain_length_unit #(
   parameter int MAX_POINTS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [chcl_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [chcl_pkg::COORD_W-1:0] req_z_coord,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [chcl_pkg::LEN_W-1:0]          rsp_chain_length,
   output logic [chcl_pkg::HULL_W-1:0]         rsp_hull_count,
   output logic [chcl_pkg::STAT_W-1:0]         rsp_status
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   chcl_pkg::dp_cmd_type  cmd;
   chcl_pkg::dp_stat_type stat;
   logic [IW-1:0] wr_addr, rd_addr;

   chcl_ctrl #(.MAX_POINTS(MAX_POINTS), .IW(IW), .CW(CW)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hull_count (rsp_hull_count),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .stat           (stat)
   );

   chcl_dp #(.IW(IW)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .wr_x         (req_x_coord),
      .wr_z         (req_z_coord),
      .stat         (stat),
      .chain_length (rsp_chain_length)
   );

endmodule
